@@ design/sfs_pkg.sv @@
// Shared types and constants of the sprite frame sequencer.
// Command codes, field widths, queue entry and divider handshake structs.
// No dependencies.
package sfs_pkg;

  localparam int MAX_FRAMES_DEF = 256;

  localparam int MODE_W   = 3;
  localparam int TSTEP_W  = 16;
  localparam int FRAME_W  = 8;
  localparam int NEWF_W   = 16;
  localparam int ACC_W    = 24;
  localparam int DUR_W    = 16;
  localparam int PIX_W    = 12;
  localparam int CNT_W    = 9;
  localparam int POS_W    = 20;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAMES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHEET_COLUMNS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_DURATION = 3'd4;

  localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PLAY  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RESET = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SET   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PREV  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_NEXT  = 3'd5;

  typedef logic [2:0] op_t;
  localparam op_t OP_TICK  = 3'd0;
  localparam op_t OP_PLAY  = 3'd1;
  localparam op_t OP_RESET = 3'd2;
  localparam op_t OP_SET   = 3'd3;
  localparam op_t OP_PREV  = 3'd4;
  localparam op_t OP_NEXT  = 3'd5;
  localparam op_t OP_NOP   = 3'd6;

  typedef struct packed {
    op_t                op;
    logic [TSTEP_W-1:0] time_step;
    logic [FRAME_W-1:0] range_start;
    logic [FRAME_W-1:0] range_end;
    logic [NEWF_W-1:0]  new_frame;
  } cmd_t;

  localparam int CMD_FIFO_DEPTH = 2;

  localparam int DIVIDEND_W       = 16;
  localparam int SHORT_DIVIDEND_W = 8;
  localparam int DIVISOR_W        = 9;
  localparam int DIV_STEPS        = 2;

  typedef struct packed {
    logic                  start;
    logic                  short_op;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [DIVISOR_W-1:0]  remainder;
  } div_rsp_t;

endpackage

@@ design/sfs_front.sv @@
// Front end: accepts stream transactions and classifies the mode into a command.
// Depends on sfs_pkg; feeds sfs_cmd_fifo.
module sfs_front
  import sfs_pkg::*;
(
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] time_step, [23:16] range_start, [31:24] range_end, [47:32] new_frame
  input  logic [IN_TDATA_W-1:0] in_tdata,
  // [2:0] mode
  input  logic [MODE_W-1:0]     in_tuser,
  input  logic                  fifo_full,
  output logic                  push,
  output cmd_t                  cmd
);

  assign in_tready = !fifo_full;
  assign push      = in_tvalid && !fifo_full;

  always_comb begin
    cmd.time_step   = in_tdata[15:0];
    cmd.range_start = in_tdata[23:16];
    cmd.range_end   = in_tdata[31:24];
    cmd.new_frame   = in_tdata[47:32];
    unique case (in_tuser)
      MODE_TICK:  cmd.op = OP_TICK;
      MODE_PLAY:  cmd.op = OP_PLAY;
      MODE_RESET: cmd.op = OP_RESET;
      MODE_SET:   cmd.op = OP_SET;
      MODE_PREV:  cmd.op = OP_PREV;
      MODE_NEXT:  cmd.op = OP_NEXT;
      default:    cmd.op = OP_NOP;
    endcase
  end

endmodule

@@ design/sfs_cmd_fifo.sv @@
// Short command queue between front end and executor.
// Depends on sfs_pkg (cmd_t, CMD_FIFO_DEPTH).
module sfs_cmd_fifo
  import sfs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t cmd_in,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t cmd_out
);

  localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CMD_FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CMD_FIFO_DEPTH);

  cmd_t             mem_r [CMD_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == FULL_CNT);
  assign valid   = (count_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign cmd_out = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

@@ design/sfs_div.sv @@
// Restoring divider, DIV_STEPS quotient bits per cycle, long or short dividend.
// Depends on sfs_pkg (div_req_t, div_rsp_t, widths).
module sfs_div
  import sfs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int LONG_ITERS  = DIVIDEND_W / DIV_STEPS;
  localparam int SHORT_ITERS = SHORT_DIVIDEND_W / DIV_STEPS;
  localparam int ITER_W      = (LONG_ITERS > 1) ? $clog2(LONG_ITERS) : 1;

  logic                  busy_r;
  logic                  done_r;
  logic [ITER_W-1:0]     cnt_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVIDEND_W-1:0] q_r;
  logic [DIVISOR_W-1:0]  divisor_r;
  logic [DIVISOR_W-1:0]  rem_step;
  logic [DIVIDEND_W-1:0] q_step;

  always_comb begin
    logic [DIVISOR_W:0] trial;
    rem_step = rem_r;
    q_step   = q_r;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial  = {rem_step, q_step[DIVIDEND_W-1]};
      q_step = {q_step[DIVIDEND_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor_r}) begin
        trial     = trial - {1'b0, divisor_r};
        q_step[0] = 1'b1;
      end
      rem_step = trial[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.short_op ? ITER_W'(SHORT_ITERS - 1) : ITER_W'(LONG_ITERS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r     <= '0;
      q_r       <= req.dividend;
      divisor_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_step;
      q_r   <= q_step;
    end
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.quotient  = q_r;
  assign rsp.remainder = rem_r;

endmodule

@@ design/sfs_back.sv @@
// Executor: configuration, animation state, frame update and sheet position.
// Depends on sfs_pkg; uses sfs_div through div_req/div_rsp, drives the output register.
module sfs_back
  import sfs_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   cmd_valid,
  input  cmd_t                   cmd,
  output logic                   cmd_pop,
  output div_req_t               div_req,
  input  div_rsp_t               div_rsp,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_TICK      = 3'd1;
  localparam logic [2:0] ST_MOD_WAIT  = 3'd2;
  localparam logic [2:0] ST_POS_START = 3'd3;
  localparam logic [2:0] ST_POS_WAIT  = 3'd4;
  localparam logic [2:0] ST_MUL       = 3'd5;
  localparam logic [2:0] ST_OUT       = 3'd6;

  localparam logic [CNT_W-1:0] TOT_CAP = CNT_W'(MAX_FRAMES);
  localparam logic [ACC_W-1:0] ACC_MAX = '1;
  localparam int OUT_PAD = OUT_TDATA_W - (FRAME_W + 1 + 2 * POS_W);

  logic [2:0]         state_r;
  logic [PIX_W-1:0]   fw_r;
  logic [PIX_W-1:0]   fh_r;
  logic [CNT_W-1:0]   total_r;
  logic [CNT_W-1:0]   cols_r;
  logic [DUR_W-1:0]   dur_r;
  logic [FRAME_W-1:0] cf_r;
  logic [ACC_W-1:0]   acc_r;
  logic               active_r;
  logic [FRAME_W-1:0] start_r;
  logic [FRAME_W-1:0] end_r;
  logic [FRAME_W-1:0] col_r;
  logic [FRAME_W-1:0] row_r;
  logic [POS_W-1:0]   x_r;
  logic [POS_W-1:0]   y_r;
  logic               out_valid_r;
  logic [FRAME_W-1:0] out_frame_r;
  logic               out_play_r;
  logic [POS_W-1:0]   out_x_r;
  logic [POS_W-1:0]   out_y_r;

  logic [CNT_W-1:0]   tot;
  logic [CNT_W-1:0]   cols;
  logic [ACC_W:0]     acc_sum;
  logic [ACC_W-1:0]   acc_sat;
  logic [CNT_W-1:0]   cf_inc;
  logic [CNT_W-1:0]   tot_dec;
  logic               out_load;

  always_comb begin
    if (total_r == '0) begin
      tot = CNT_W'(1);
    end else if (32'(total_r) > MAX_FRAMES) begin
      tot = TOT_CAP;
    end else begin
      tot = total_r;
    end
  end

  assign cols     = (cols_r == '0) ? CNT_W'(1) : cols_r;
  assign acc_sum  = {1'b0, acc_r} + (ACC_W + 1)'(cmd.time_step);
  assign acc_sat  = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
  assign cf_inc   = {1'b0, cf_r} + CNT_W'(1);
  assign tot_dec  = tot - CNT_W'(1);
  assign cmd_pop  = (state_r == ST_IDLE) && cmd_valid;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.short_op = 1'b0;
    div_req.dividend = DIVIDEND_W'(cmd.new_frame);
    div_req.divisor  = tot;
    if (state_r == ST_POS_START) begin
      div_req.start    = 1'b1;
      div_req.short_op = 1'b1;
      div_req.dividend = {cf_r, {(DIVIDEND_W - FRAME_W){1'b0}}};
      div_req.divisor  = cols;
    end else if (cmd_pop && (cmd.op == OP_SET || cmd.op == OP_NEXT)) begin
      div_req.start = 1'b1;
      if (cmd.op == OP_NEXT) begin
        div_req.dividend = DIVIDEND_W'(cf_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fw_r        <= '0;
      fh_r        <= '0;
      total_r     <= CNT_W'(1);
      cols_r      <= CNT_W'(1);
      dur_r       <= DUR_W'(410);
      cf_r        <= '0;
      acc_r       <= '0;
      active_r    <= 1'b0;
      start_r     <= '0;
      end_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (cmd_valid) begin
            state_r <= ST_POS_START;
            unique case (cmd.op)
              OP_TICK: begin
                if (active_r) begin
                  acc_r   <= acc_sat;
                  state_r <= ST_TICK;
                end
              end
              OP_PLAY: begin
                if (!active_r) begin
                  start_r  <= cmd.range_start;
                  end_r    <= cmd.range_end;
                  cf_r     <= cmd.range_start;
                  acc_r    <= '0;
                  active_r <= 1'b1;
                end
              end
              OP_RESET: begin
                cf_r  <= '0;
                acc_r <= '0;
              end
              OP_SET, OP_NEXT: state_r <= ST_MOD_WAIT;
              OP_PREV: begin
                cf_r <= (cf_r == '0) ? tot_dec[FRAME_W-1:0] : cf_r - 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_TICK: begin
          if (acc_r >= ACC_W'(dur_r)) begin
            acc_r <= acc_r - ACC_W'(dur_r);
            if (cf_inc > {1'b0, end_r}) begin
              cf_r     <= start_r;
              active_r <= 1'b0;
            end else begin
              cf_r <= cf_inc[FRAME_W-1:0];
            end
          end
          state_r <= ST_POS_START;
        end
        ST_MOD_WAIT: begin
          if (div_rsp.done) begin
            cf_r    <= div_rsp.remainder[FRAME_W-1:0];
            state_r <= ST_POS_START;
          end
        end
        ST_POS_START: state_r <= ST_POS_WAIT;
        ST_POS_WAIT: begin
          if (div_rsp.done) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: state_r <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:    fw_r    <= cfg_wdata[PIX_W-1:0];
          CFG_FRAME_HEIGHT:   fh_r    <= cfg_wdata[PIX_W-1:0];
          CFG_TOTAL_FRAMES:   total_r <= cfg_wdata[CNT_W-1:0];
          CFG_SHEET_COLUMNS:  cols_r  <= cfg_wdata[CNT_W-1:0];
          CFG_FRAME_DURATION: dur_r   <= cfg_wdata[DUR_W-1:0];
          default: ;
        endcase
        if (cfg_index <= CFG_FRAME_DURATION) begin
          cf_r  <= '0;
          acc_r <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_POS_WAIT && div_rsp.done) begin
      col_r <= div_rsp.remainder[FRAME_W-1:0];
      row_r <= div_rsp.quotient[FRAME_W-1:0];
    end
    if (state_r == ST_MUL) begin
      x_r <= POS_W'(col_r) * POS_W'(fw_r);
      y_r <= POS_W'(row_r) * POS_W'(fh_r);
    end
    if (out_load) begin
      out_frame_r <= cf_r;
      out_play_r  <= active_r;
      out_x_r     <= x_r;
      out_y_r     <= y_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_y_r, out_x_r, out_play_r, out_frame_r};

endmodule

@@ design/sprite_frame_sequencer.sv @@
// Sprite-sheet frame sequencer: one result transaction per command transaction.
// From queue entry to output register: set and next commands first take a modulo by
// frame count, active tick commands pass the accumulator check, then every command takes
// row and column by sheet columns in the shared two-bit-per-cycle divider and a multiply.
// A two-entry command queue takes new commands while one executes or a result waits.
// Synchronous active-low reset: empty queue, no result pending, reset register values.
module sprite_frame_sequencer
  import sfs_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [15:0] time_step, [23:16] range_start, [31:24] range_end, [47:32] new_frame
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [2:0] mode
  input  logic [MODE_W-1:0]      in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] frame_index, [8] is_playing, [28:9] source_x, [48:29] source_y, rest zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic     fifo_full;
  logic     push;
  cmd_t     cmd_in;
  logic     cmd_valid;
  cmd_t     cmd_out;
  logic     cmd_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  sfs_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .fifo_full (fifo_full),
    .push      (push),
    .cmd       (cmd_in)
  );

  sfs_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .cmd_in  (cmd_in),
    .full    (fifo_full),
    .pop     (cmd_pop),
    .valid   (cmd_valid),
    .cmd_out (cmd_out)
  );

  sfs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  sfs_back #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd_out),
    .cmd_pop    (cmd_pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_div_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |=> !div_rsp.done)
    else $error("divider done held for more than one cycle");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule
